/* rtl/bls_pkg.sv */
// Shared types and constants for the bounded LIFO stack with search.
// Depends on nothing; every other source file except bls_ram imports it.
package bls_pkg;

    // Storage geometry
    localparam int DEPTH   = 256;
    localparam int ELEM_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the channels and the capacity register
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int FILL_W  = 9;
    localparam int CAP_W   = 9;

    // Operation codes
    typedef enum logic [2:0] {
        MODE_PUSH     = 3'd0,
        MODE_POP      = 3'd1,
        MODE_PEEK_TOP = 3'd2,
        MODE_PEEK_AT  = 3'd3,
        MODE_INDEX_OF = 3'd4,
        MODE_CLEAR    = 3'd5
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_DELIVER
    } seq_state_t;

    // Request payload
    typedef struct packed {
        mode_t                mode;
        logic [VALUE_W-1:0]   value;
        logic [POS_W-1:0]     position;
    } req_t;

    // Response payload
    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   read_data;
        logic [POS_W-1:0]     found_position;
        logic [FILL_W-1:0]    fill_count;
        logic                 is_empty;
        logic                 is_full;
    } rsp_t;

    // Entry storage access, sequencer to RAM
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [ELEM_W-1:0]    wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } ram_port_t;

endpackage

/* rtl/bls_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package needed.
module bls_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bls_out.sv */
// Output register stage for the response channel.
// Depends on bls_pkg for the response type.
module bls_out
    import bls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t din,
    output logic free,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic valid_reg, valid_next;
    rsp_t data_reg;

    // Slot can take a new response when empty or draining this cycle
    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

/* rtl/bls_seq.sv */
// Operation sequencer: fill count, RAM read-modify sequencing, upward search walk.
// Depends on bls_pkg for types and geometry.
module bls_seq
    import bls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    input  logic [CNT_W-1:0]  cap_eff,
    output ram_port_t         ram,
    input  logic [ELEM_W-1:0] ram_rdata,
    input  logic              out_free,
    output logic              out_load,
    output rsp_t              out_din
);

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [ELEM_W-1:0] key_reg, key_next;
    rsp_t              pend_reg, pend_next;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  scan_inc;

    assign count_dec = count_reg - CNT_W'(1);
    assign scan_inc  = CNT_W'(scan_reg) + CNT_W'(1);

    // Next state, storage access and response staging
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        key_next   = key_reg;
        pend_next  = pend_reg;
        ram.we     = 1'b0;
        ram.waddr  = count_reg[ADDR_W-1:0];
        ram.wdata  = req.value[ELEM_W-1:0];
        ram.re     = 1'b0;
        ram.raddr  = '0;
        req_ready  = (state_reg == ST_IDLE);
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    pend_next  = '0;
                    state_next = ST_DELIVER;
                    unique case (req.mode)
                        MODE_PUSH:
                        begin
                            if (count_reg < cap_eff)
                            begin
                                ram.we       = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                pend_next.ok = 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                ram.re       = 1'b1;
                                ram.raddr    = count_dec[ADDR_W-1:0];
                                count_next   = count_dec;
                                pend_next.ok = 1'b1;
                                state_next   = ST_READ;
                            end
                        end
                        MODE_PEEK_TOP:
                        begin
                            if (count_reg != '0)
                            begin
                                ram.re       = 1'b1;
                                ram.raddr    = count_dec[ADDR_W-1:0];
                                pend_next.ok = 1'b1;
                                state_next   = ST_READ;
                            end
                        end
                        MODE_PEEK_AT:
                        begin
                            if (CNT_W'(req.position) < count_reg)
                            begin
                                ram.re       = 1'b1;
                                ram.raddr    = ADDR_W'(req.position);
                                pend_next.ok = 1'b1;
                                state_next   = ST_READ;
                            end
                        end
                        MODE_INDEX_OF:
                        begin
                            key_next = req.value[ELEM_W-1:0];
                            if (count_reg != '0)
                            begin
                                ram.re     = 1'b1;
                                ram.raddr  = '0;
                                scan_next  = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next   = '0;
                            pend_next.ok = 1'b1;
                        end
                        default:
                        begin
                            // unused codes: no operation, refused
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // capture the word read at accept
                pend_next.read_data = VALUE_W'(ram_rdata);
                state_next          = ST_DELIVER;
            end
            ST_SEARCH:
            begin
                // compare entry at scan_reg, then advance or stop
                if (ram_rdata == key_reg)
                begin
                    pend_next.ok             = 1'b1;
                    pend_next.found_position = POS_W'(scan_reg);
                    state_next               = ST_DELIVER;
                end
                else if (scan_inc == count_reg)
                begin
                    state_next = ST_DELIVER;
                end
                else
                begin
                    ram.re     = 1'b1;
                    ram.raddr  = scan_inc[ADDR_W-1:0];
                    scan_next  = scan_inc[ADDR_W-1:0];
                end
            end
            ST_DELIVER:
            begin
                // hand the response to the output slot once it is free
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Status fields follow the count as it stands after the operation
    always_comb
    begin
        out_din            = pend_reg;
        out_din.fill_count = FILL_W'(count_reg);
        out_din.is_empty   = (count_reg == '0);
        out_din.is_full    = (count_reg >= cap_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        key_reg  <= key_next;
        pend_reg <= pend_next;
    end

endmodule

/* rtl/bounded_lifo_stack_with_search.sv */
// Top level of the bounded LIFO stack with search: capacity register and wiring.
// Depends on bls_pkg, bls_ram, bls_seq and bls_out.
//
// Usage:
//   Requests arrive on req (mode, value, position) with req_valid/req_ready;
//   one response per request leaves on rsp with rsp_valid/rsp_ready.
//   cfg_we writes cfg_wdata into the capacity limit; values above 256 act as 256.
//   Write it only while no request is in flight.
// Sequence (from the accepting edge to rsp_valid; the next accept can follow then):
//   push, clear, refused ops : DELIVER, then the output register
//   pop, peek top, peek at   : READ, DELIVER, then the output register
//   index of, hit at p       : SEARCH over entries 0 to p, DELIVER, output register
//   index of, miss           : SEARCH over entries below count, DELIVER, output register
//   The entry RAM has one read port; the search walks it one entry per cycle.
//   One request is in flight at a time, so a write and a read never touch the
//   same entry in one cycle.
// Reset: count clears to zero, capacity returns to 256; entries are not cleared
//   and need no pass, since only entries below the count are ever read.
// Stall: a waiting response sits in the output register; the next request is
//   still accepted and worked, and holds in the sequencer until the slot frees.
module bounded_lifo_stack_with_search
    import bls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  cap_eff;
    ram_port_t         ram;
    logic [ELEM_W-1:0] ram_rdata;
    logic              out_free;
    logic              out_load;
    rsp_t              out_din;

    // Capacity limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(DEPTH);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Saturate capacity to the storage depth
    assign cap_eff = (cap_reg > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);

    bls_ram #(
        .DATA_W (ELEM_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (ram_rdata)
    );

    bls_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cap_eff   (cap_eff),
        .ram       (ram),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_din   (out_din)
    );

    bls_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .din       (out_din),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/bls_checker.sv */
// Port-level checks for the bounded LIFO stack, bound to the top level.
// Depends on bls_pkg and on the top-level port list.
module bls_checker
    import bls_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input rsp_t             rsp
);

    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted on two consecutive edges");

    // Fill count never exceeds the storage depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.fill_count <= FILL_W'(DEPTH)))
        else $error("fill count above depth");

    // Empty flag tracks the fill count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    // Refused or failed operations return zero data and position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.read_data == '0 && rsp.found_position == '0))
        else $error("nonzero data on a refused operation");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

endmodule

bind bounded_lifo_stack_with_search bls_checker u_bls_checker (.*);

/* tb/bounded_lifo_stack_with_search_tb.sv */
// Self-checking testbench for the bounded LIFO stack with search.
// Depends on bls_pkg and the bounded_lifo_stack_with_search RTL; predicts every
// response in step with accepted requests and checks each response transfer.
`timescale 1ns / 100ps

module bounded_lifo_stack_with_search_tb;
    import bls_pkg::*;

    // Codes the mode field can carry that name no operation
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;
    logic             cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    // Shadow copy of the stack and its capacity register
    logic [ELEM_W-1:0] shadow_entries [DEPTH];
    int                shadow_count = 0;
    logic [CAP_W-1:0]  shadow_capacity = CAP_W'(256);

    rsp_t pending_rsps [$];
    int   error_count = 0;
    bit   gaps_on = 1'b1;
    bit   filling = 1'b1;

    bounded_lifo_stack_with_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Work out the response of one request and advance the shadow stack
    function automatic rsp_t stack_response(req_t item);
        rsp_t r;
        int   cap;
        r = '0;
        cap = (int'(shadow_capacity) > DEPTH) ? DEPTH : int'(shadow_capacity);
        case (item.mode)
            MODE_PUSH:
            begin
                if (shadow_count < cap)
                begin
                    shadow_entries[shadow_count] = item.value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    r.read_data = shadow_entries[shadow_count];
                    r.ok = 1'b1;
                end
            end
            MODE_PEEK_TOP:
            begin
                if (shadow_count > 0)
                begin
                    r.read_data = shadow_entries[shadow_count - 1];
                    r.ok = 1'b1;
                end
            end
            MODE_PEEK_AT:
            begin
                if (int'(item.position) < shadow_count)
                begin
                    r.read_data = shadow_entries[item.position];
                    r.ok = 1'b1;
                end
            end
            MODE_INDEX_OF:
            begin
                // lowest matching position wins
                for (int i = 0; i < shadow_count && !r.ok; i++)
                begin
                    if (shadow_entries[i] == item.value)
                    begin
                        r.ok = 1'b1;
                        r.found_position = POS_W'(i);
                    end
                end
            end
            MODE_CLEAR:
            begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.fill_count = FILL_W'(shadow_count);
        r.is_empty = (shadow_count == 0);
        r.is_full = (shadow_count >= cap);
        return r;
    endfunction

    // Drive the response ready, stalling at random while gaps are on
    always @(posedge clk)
    begin
        rsp_ready <= !gaps_on || ($urandom_range(99) >= 23);
    end

    // Check each response transfer against the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    $error("ok: expected %0d actual %0d", want.ok, rsp.ok);
                    error_count++;
                end
                if (rsp.read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h actual %0h", want.read_data, rsp.read_data);
                    error_count++;
                end
                if (rsp.found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d actual %0d",
                           want.found_position, rsp.found_position);
                    error_count++;
                end
                if (rsp.fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d actual %0d", want.fill_count, rsp.fill_count);
                    error_count++;
                end
                if (rsp.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d actual %0d", want.is_empty, rsp.is_empty);
                    error_count++;
                end
                if (rsp.is_full !== want.is_full)
                begin
                    $error("is_full: expected %0d actual %0d", want.is_full, rsp.is_full);
                    error_count++;
                end
            end
        end
    end

    // Offer one request, hold it until the transfer, then record its prediction
    task automatic send_request(input logic [2:0] op, input logic [VALUE_W-1:0] word,
                                input logic [POS_W-1:0] pos);
        req_t item;
        item.mode = mode_t'(op);
        item.value = word;
        item.position = pos;
        if (gaps_on && $urandom_range(99) < 23)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 23);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!req_ready);
        pending_rsps.push_back(stack_response(item));
    endtask

    // Drop valid and wait until every predicted response has arrived
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the capacity register while the stack is idle
    task automatic write_capacity(input logic [CAP_W-1:0] limit);
        drain_responses();
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        shadow_capacity = limit;
        cfg_we <= 1'b0;
    endtask

    // Refusals on an empty stack, and the spare mode codes
    task automatic test_empty_refusals();
        send_request(MODE_POP, 32'h0, 8'd0);
        send_request(MODE_PEEK_TOP, 32'h0, 8'd0);
        send_request(MODE_PEEK_AT, 32'h0, 8'd0);
        send_request(MODE_INDEX_OF, 32'h0, 8'd0);
        send_request(MODE_SPARE_6, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_SPARE_7, 32'hDEAD_BEEF, 8'h5A);
    endtask

    // Every operation with extreme values, a duplicate search and a miss
    task automatic test_operations();
        send_request(MODE_PUSH, 32'h0000_0000, 8'd0);
        send_request(MODE_PUSH, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_PUSH, 32'h1234_5678, 8'd0);
        send_request(MODE_PUSH, 32'h0000_0000, 8'd0);
        send_request(MODE_PEEK_TOP, 32'h0, 8'd0);
        send_request(MODE_PEEK_AT, 32'h0, 8'd1);
        send_request(MODE_PEEK_AT, 32'h0, 8'd255);
        send_request(MODE_INDEX_OF, 32'h0000_0000, 8'd0);
        send_request(MODE_INDEX_OF, 32'h1234_5678, 8'd0);
        send_request(MODE_INDEX_OF, 32'h8000_0001, 8'd0);
        send_request(MODE_POP, 32'h0, 8'd0);
        send_request(MODE_CLEAR, 32'h0, 8'd0);
    endtask

    // Zero capacity, filling to the limit, a limit below the count, saturation
    task automatic test_capacity_edges();
        write_capacity(CAP_W'(0));
        send_request(MODE_PUSH, 32'hAAAA_5555, 8'd0);
        write_capacity(CAP_W'(2));
        send_request(MODE_PUSH, 32'h5555_AAAA, 8'd0);
        send_request(MODE_PUSH, 32'h0F0F_F0F0, 8'd0);
        send_request(MODE_PUSH, 32'hF0F0_0F0F, 8'd0);
        write_capacity(CAP_W'(1));
        send_request(MODE_PUSH, 32'h1111_1111, 8'd0);
        send_request(MODE_POP, 32'h0, 8'd0);
        write_capacity(CAP_W'(511));
        send_request(MODE_PUSH, 32'h2222_2222, 8'd0);
    endtask

    // Pick a word, often from a small pool so searches meet duplicates
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Send one random request, biased to fill up then to drain
    task automatic send_random_request();
        int               roll;
        int               cap;
        logic [2:0]       op;
        logic [VALUE_W-1:0] word;
        logic [POS_W-1:0] pos;
        cap = (int'(shadow_capacity) > DEPTH) ? DEPTH : int'(shadow_capacity);
        if (shadow_count >= cap)
            filling = 1'b0;
        else if (shadow_count == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
        begin
            if (roll < 60)       op = MODE_PUSH;
            else if (roll < 68)  op = MODE_POP;
            else if (roll < 74)  op = MODE_PEEK_TOP;
            else if (roll < 84)  op = MODE_PEEK_AT;
            else if (roll < 96)  op = MODE_INDEX_OF;
            else if (roll < 97)  op = MODE_CLEAR;
            else if (roll < 98)  op = MODE_SPARE_6;
            else                 op = MODE_SPARE_7;
        end
        else
        begin
            if (roll < 10)       op = MODE_PUSH;
            else if (roll < 65)  op = MODE_POP;
            else if (roll < 71)  op = MODE_PEEK_TOP;
            else if (roll < 81)  op = MODE_PEEK_AT;
            else if (roll < 96)  op = MODE_INDEX_OF;
            else if (roll < 97)  op = MODE_CLEAR;
            else if (roll < 98)  op = MODE_SPARE_6;
            else                 op = MODE_SPARE_7;
        end
        word = pick_word();
        // search mostly for values the stack holds
        if (op == MODE_INDEX_OF && shadow_count > 0 && $urandom_range(99) < 75)
            word = shadow_entries[$urandom_range(shadow_count - 1)];
        if (shadow_count > 0 && $urandom_range(99) < 80)
            pos = POS_W'($urandom_range(shadow_count - 1));
        else
            pos = POS_W'($urandom_range(255));
        send_request(op, word, pos);
    endtask

    // One setting of the capacity, then a run of random requests
    task automatic test_random_phase(input logic [CAP_W-1:0] limit, input int count,
                                     input bit open_with_clear, input int quiet_from,
                                     input int quiet_to);
        write_capacity(limit);
        filling = 1'b1;
        if (open_with_clear)
            send_request(MODE_CLEAR, 32'h0, 8'd0);
        for (int n = 0; n < count; n++)
        begin
            gaps_on = !(n >= quiet_from && n < quiet_to);
            send_random_request();
        end
        gaps_on = 1'b1;
    endtask

    // Run limit
    initial
    begin
        #20_000_000;
        $display("bounded_lifo_stack_with_search_tb failed");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_refusals();
        test_operations();
        test_capacity_edges();

        test_random_phase(CAP_W'(256), 500, 1'b1, 100, 260);
        test_random_phase(CAP_W'(511), 400, 1'b0, 0, 0);
        test_random_phase(CAP_W'(130), 150, 1'b0, 0, 0);
        test_random_phase(CAP_W'(255), 150, 1'b0, 0, 0);
        test_random_phase(CAP_W'(3), 100, 1'b1, 40, 70);
        test_random_phase(CAP_W'(1), 100, 1'b1, 0, 0);
        test_random_phase(CAP_W'(0), 50, 1'b0, 0, 0);
        test_random_phase(CAP_W'($urandom_range(1, 511)), 200, 1'b0, 0, 0);

        drain_responses();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_rsps.size() == 0)
            $display("bounded_lifo_stack_with_search_tb passed");
        else
            $display("bounded_lifo_stack_with_search_tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/bls_pkg.sv
rtl/bls_ram.sv
rtl/bls_out.sv
rtl/bls_seq.sv
rtl/bounded_lifo_stack_with_search.sv
rtl/bls_checker.sv
tb/bounded_lifo_stack_with_search_tb.sv
